### src/fbpa_pkg.sv
// ----------------------------------------------------------------------------
// fbpa_pkg
// Shared types and constants of the fixed-size block pool allocator.
// ----------------------------------------------------------------------------
package fbpa_pkg;

    // default geometry
    localparam int MAX_BLOCKS_DEF = 256;
    localparam int ADDR_BITS_DEF  = 32;

    // field widths
    localparam int ACTION_W = 2;
    localparam int BYTES_W  = 17;
    localparam int BCOUNT_W = 9;
    localparam int DATA_W   = 32;
    localparam int COUNT_W  = 25;
    localparam int STATUS_W = 2;
    localparam int CFG_IDX_W = 2;

    // packed stream widths
    localparam int S_TDATA_W = 56;
    localparam int M_TDATA_W = 88;

    // saturation limit of the byte counters
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // register reset values
    localparam logic [DATA_W-1:0]   BASE_RST  = '0;
    localparam logic [BYTES_W-1:0]  BYTES_RST = BYTES_W'(8);
    localparam logic [BCOUNT_W-1:0] COUNT_RST = BCOUNT_W'(256);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BASE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BYTES = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COUNT = 2'd2;

    // action codes
    localparam logic [ACTION_W-1:0] ACT_ALLOC  = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_FREE   = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_REINIT = 2'd2;

    // result status
    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_SIZE  = 2'd2,
        ST_FULL  = 2'd3
    } t_status;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_ALLOC_ADD,
        S_PEAK,
        S_FREE_SUB,
        S_FILL,
        S_FINISH
    } t_state;

endpackage

### src/fbpa_ram.sv
// ----------------------------------------------------------------------------
// fbpa_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module fbpa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### src/fbpa_addsub.sv
// ----------------------------------------------------------------------------
// fbpa_addsub
// Shared adder/subtractor used for the address walk and the byte counters.
// ----------------------------------------------------------------------------
module fbpa_addsub #(
    parameter int WIDTH = 32
) (
    input  logic             i_sub,
    input  logic [WIDTH-1:0] i_a,
    input  logic [WIDTH-1:0] i_b,
    output logic [WIDTH-1:0] o_sum,
    output logic             o_carry
);

    // carry out on add, borrow out on subtract
    always_comb begin
        if (i_sub) begin
            {o_carry, o_sum} = {1'b0, i_a} - {1'b0, i_b};
        end else begin
            {o_carry, o_sum} = {1'b0, i_a} + {1'b0, i_b};
        end
    end

endmodule

### src/fixed_block_pool_allocator.sv
// ----------------------------------------------------------------------------
// fixed_block_pool_allocator
// Fixed-size block pool with a LIFO stack of free block addresses.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive on the s_axis channel: tuser carries the action
//   (allocate, free, reinitialize), tdata the request size and the address
//   of a block being returned. Each request gives one result beat on
//   m_axis: the allocated address in tdata with the used and peak byte
//   counts, and the status code in tuser.
//   Registers (base address, block size, block count) are written on the
//   cfg channel, which is always ready; write them only while idle.
//   Steps from an accepted beat to its result beat: stack read, counter add
//   and peak compare for a good allocate, stack write and counter subtract
//   for a good free, none for a rejected or unknown request, and for a
//   reinitialize a fill that writes one stack entry per cycle through the
//   shared adder. One request is in work at a time; s_axis_tready is high
//   only while the sequencer is idle.
//   After reset the stack is empty until a free or reinitialize. A result
//   waits in the output register while the receiver stalls; the next
//   request is taken meanwhile and holds in its last step until the
//   output register frees.
// ----------------------------------------------------------------------------
module fixed_block_pool_allocator
    import fbpa_pkg::*;
#(
    parameter int MAX_BLOCKS = MAX_BLOCKS_DEF,
    parameter int ADDR_BITS  = ADDR_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration write channel
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [DATA_W-1:0]    i_cfg_data,
    // request stream
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // request_size[16:0], block_address[48:17], zero pad [55:49]
    input  logic [S_TDATA_W-1:0] s_axis_tdata,
    // action[1:0]
    input  logic [ACTION_W-1:0]  s_axis_tuser,
    // result stream
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // result_address[31:0], used_bytes[56:32], peak_bytes[81:57], zero pad [87:82]
    output logic [M_TDATA_W-1:0] m_axis_tdata,
    // status[1:0]
    output logic [STATUS_W-1:0]  m_axis_tuser
);

    localparam int IDX_W  = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int CNT_W  = $clog2(MAX_BLOCKS + 1);
    localparam int CMP_W  = (CNT_W > BCOUNT_W) ? CNT_W : BCOUNT_W;
    localparam int UNIT_W = (ADDR_BITS > COUNT_W + 1) ? ADDR_BITS : COUNT_W + 1;

    // control state
    t_state                r_state, n_state;
    logic                  r_out_valid, n_out_valid;
    logic [CNT_W-1:0]      r_depth, n_depth;
    logic [COUNT_W-1:0]    r_used, n_used;
    logic [COUNT_W-1:0]    r_peak, n_peak;
    logic [DATA_W-1:0]     r_cfg_base, n_cfg_base;
    logic [BYTES_W-1:0]    r_cfg_bytes, n_cfg_bytes;
    logic [BCOUNT_W-1:0]   r_cfg_count, n_cfg_count;

    // working and payload registers
    logic [CNT_W-1:0]      r_idx, n_idx;
    logic [ADDR_BITS-1:0]  r_walk, n_walk;
    logic [DATA_W-1:0]     r_res_addr, n_res_addr;
    t_status               r_status, n_status;
    logic [DATA_W-1:0]     r_out_addr, n_out_addr;
    t_status               r_out_status, n_out_status;
    logic [COUNT_W-1:0]    r_out_used, n_out_used;
    logic [COUNT_W-1:0]    r_out_peak, n_out_peak;

    // stack memory and shared unit hookup
    logic                  w_ram_we, w_ram_re;
    logic [IDX_W-1:0]      w_ram_waddr;
    logic [ADDR_BITS-1:0]  w_ram_wdata, w_ram_rdata;
    logic                  w_unit_sub, w_unit_carry;
    logic [UNIT_W-1:0]     w_unit_a, w_unit_sum;

    logic [CNT_W-1:0]      w_pool, w_depth_dec;
    logic [CMP_W-1:0]      w_count_ext, w_max_ext;
    logic [BYTES_W-1:0]    w_req;
    logic [DATA_W-1:0]     w_addr_in;

    assign w_req       = s_axis_tdata[16:0];
    assign w_addr_in   = s_axis_tdata[48:17];
    assign w_depth_dec = CNT_W'(r_depth - 1'b1);

    // effective block count: register value limited to the stack size
    assign w_count_ext = CMP_W'(r_cfg_count);
    assign w_max_ext   = CMP_W'(MAX_BLOCKS);
    assign w_pool      = (w_count_ext > w_max_ext) ? CNT_W'(w_max_ext) : CNT_W'(w_count_ext);

    fbpa_ram #(
        .WIDTH (ADDR_BITS),
        .DEPTH (MAX_BLOCKS),
        .AW    (IDX_W)
    ) u_stack (
        .i_clk     (i_clk),
        .i_wr_en   (w_ram_we),
        .i_wr_addr (w_ram_waddr),
        .i_wr_data (w_ram_wdata),
        .i_rd_en   (w_ram_re),
        .i_rd_addr (w_depth_dec[IDX_W-1:0]),
        .o_rd_data (w_ram_rdata)
    );

    fbpa_addsub #(
        .WIDTH (UNIT_W)
    ) u_addsub (
        .i_sub   (w_unit_sub),
        .i_a     (w_unit_a),
        .i_b     (UNIT_W'(r_cfg_bytes)),
        .o_sum   (w_unit_sum),
        .o_carry (w_unit_carry)
    );

    // sequencer: next state and datapath control
    always_comb begin
        n_state      = r_state;
        n_out_valid  = r_out_valid;
        n_depth      = r_depth;
        n_used       = r_used;
        n_peak       = r_peak;
        n_cfg_base   = r_cfg_base;
        n_cfg_bytes  = r_cfg_bytes;
        n_cfg_count  = r_cfg_count;
        n_idx        = r_idx;
        n_walk       = r_walk;
        n_res_addr   = r_res_addr;
        n_status     = r_status;
        n_out_addr   = r_out_addr;
        n_out_status = r_out_status;
        n_out_used   = r_out_used;
        n_out_peak   = r_out_peak;
        w_ram_we     = 1'b0;
        w_ram_re     = 1'b0;
        w_ram_waddr  = r_idx[IDX_W-1:0];
        w_ram_wdata  = r_walk;
        w_unit_sub   = 1'b0;
        w_unit_a     = UNIT_W'(r_used);

        // register writes
        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_BASE:  n_cfg_base  = i_cfg_data;
                CFG_BYTES: n_cfg_bytes = BYTES_W'(i_cfg_data);
                CFG_COUNT: n_cfg_count = BCOUNT_W'(i_cfg_data);
                default: ;
            endcase
        end

        // result beat taken by the receiver
        if (r_out_valid && m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_res_addr = '0;
                    n_status   = ST_OK;
                    n_state    = S_FINISH;
                    unique case (s_axis_tuser)
                        ACT_ALLOC: begin
                            if (w_req != r_cfg_bytes) begin
                                n_status = ST_SIZE;
                            end else if (r_depth == '0) begin
                                n_status = ST_EMPTY;
                            end else begin
                                w_ram_re = 1'b1;
                                n_depth  = w_depth_dec;
                                n_state  = S_ALLOC_ADD;
                            end
                        end
                        ACT_FREE: begin
                            if (r_depth >= w_pool) begin
                                n_status = ST_FULL;
                            end else begin
                                w_ram_we    = 1'b1;
                                w_ram_waddr = r_depth[IDX_W-1:0];
                                w_ram_wdata = ADDR_BITS'(w_addr_in);
                                n_depth     = CNT_W'(r_depth + 1'b1);
                                n_state     = S_FREE_SUB;
                            end
                        end
                        ACT_REINIT: begin
                            n_used  = '0;
                            n_peak  = '0;
                            n_walk  = ADDR_BITS'(r_cfg_base);
                            n_idx   = '0;
                            n_depth = w_pool;
                            if (w_pool != '0) begin
                                n_state = S_FILL;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            // popped address arrives, add block size with saturation
            S_ALLOC_ADD: begin
                n_res_addr = DATA_W'(w_ram_rdata);
                if ((w_unit_sum >> COUNT_W) != '0) begin
                    n_used = COUNT_MAX;
                end else begin
                    n_used = w_unit_sum[COUNT_W-1:0];
                end
                n_state = S_PEAK;
            end
            S_PEAK: begin
                if (r_used > r_peak) begin
                    n_peak = r_used;
                end
                n_state = S_FINISH;
            end
            // subtract block size, floor at zero
            S_FREE_SUB: begin
                w_unit_sub = 1'b1;
                n_used     = w_unit_carry ? '0 : w_unit_sum[COUNT_W-1:0];
                n_state    = S_FINISH;
            end
            // one stack entry per cycle, next address from the shared adder
            S_FILL: begin
                w_ram_we = 1'b1;
                w_unit_a = UNIT_W'(r_walk);
                n_walk   = w_unit_sum[ADDR_BITS-1:0];
                n_idx    = CNT_W'(r_idx + 1'b1);
                if (CNT_W'(r_idx + 1'b1) == r_depth) begin
                    n_state = S_FINISH;
                end
            end
            // load the output register once it is free
            S_FINISH: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_out_valid  = 1'b1;
                    n_out_addr   = r_res_addr;
                    n_out_status = r_status;
                    n_out_used   = r_used;
                    n_out_peak   = r_peak;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_depth     <= '0;
            r_used      <= '0;
            r_peak      <= '0;
            r_cfg_base  <= BASE_RST;
            r_cfg_bytes <= BYTES_RST;
            r_cfg_count <= COUNT_RST;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_depth     <= n_depth;
            r_used      <= n_used;
            r_peak      <= n_peak;
            r_cfg_base  <= n_cfg_base;
            r_cfg_bytes <= n_cfg_bytes;
            r_cfg_count <= n_cfg_count;
        end
    end

    // working and payload registers
    always_ff @(posedge i_clk) begin
        r_idx        <= n_idx;
        r_walk       <= n_walk;
        r_res_addr   <= n_res_addr;
        r_status     <= n_status;
        r_out_addr   <= n_out_addr;
        r_out_status <= n_out_status;
        r_out_used   <= n_out_used;
        r_out_peak   <= n_out_peak;
    end

    // ports
    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {6'b0, r_out_peak, r_out_used, r_out_addr};
    assign m_axis_tuser  = r_out_status;

endmodule
